### hdl/pfx_pkg.sv
package pfx_pkg;

  localparam int DEF_STACK_DEPTH = 128;
  localparam int DEF_VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    TK_DIGIT = 3'd0,
    TK_ADD   = 3'd1,
    TK_SUB   = 3'd2,
    TK_MUL   = 3'd3,
    TK_DIV   = 3'd4,
    TK_END   = 3'd5
  } token_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_READY    = 3'd2,
    ST_ILLEGAL  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_DIVZERO  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_DIV,
    S_NEG,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SOP_NONE,
    SOP_PUSH,
    SOP_POP,
    SOP_CLEAR
  } stack_op_t;

endpackage

### hdl/postfix_expression_evaluator_unit.sv
// Postfix stack calculator, one status beat out for every token beat in.
// Digit, end and short-stack tokens go from accept straight to the done
// state. Add and subtract pass through fetch. Multiply and divide then run
// one bit per cycle through the shared adder, divide then negating if the
// signs differ. One token at a time; s_tready is high only while idle.
// Synchronous reset empties the stack and drops any pending result.
module postfix_expression_evaluator_unit
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] digit_value, [7:4] zero
  input  logic [2:0]  s_tuser,   // [2:0] token_kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int W  = VALUE_WIDTH;
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(W);

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rd_data;

  state_t      state, state_next;
  logic [CW-1:0] count, count_next;
  logic [W-1:0] tos, tos_next;
  logic [W-1:0] opa, opa_next;
  logic [W-1:0] opb, opb_next;
  logic [W-1:0] acc, acc_next;
  logic [SW-1:0] step, step_next;
  logic        neg, neg_next;
  logic [2:0]  kind_q, kind_q_next;
  status_t     res_status, res_status_next;
  logic [W-1:0] res_value, res_value_next;
  stack_op_t   sop, sop_next;
  logic        m_tvalid_next;
  logic [31:0] m_tdata_next;
  logic [2:0]  m_tuser_next;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] rd_addr;
  logic          accept;

  logic [W-1:0] add_a, add_b;
  logic         add_sub;
  logic [W:0]   add_sum;

  logic [W-1:0] rem_sh;
  logic [W-1:0] s_mag, t_mag;
  logic         last_step;
  logic         out_free;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign rd_addr   = IW'(count - CW'(2));
  assign add_sum   = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (W+1)'(add_sub);
  assign rem_sh    = {opa[W-2:0], acc[W-1]};
  assign s_mag     = rd_data[W-1] ? (~rd_data + W'(1)) : rd_data;
  assign t_mag     = tos[W-1] ? (~tos + W'(1)) : tos;
  assign last_step = (step == SW'(W - 1));
  assign out_free  = !m_tvalid || m_tready;

  // shared adder operand select
  always_comb begin
    add_a   = acc;
    add_b   = opa;
    add_sub = 1'b0;
    unique case (state)
      S_FETCH: begin
        add_a   = rd_data;
        add_b   = tos;
        add_sub = (kind_q == TK_SUB);
      end
      S_DIV: begin
        add_a   = rem_sh;
        add_b   = opb;
        add_sub = 1'b1;
      end
      S_NEG: begin
        add_a   = '0;
        add_b   = acc;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = acc;
        add_b   = opa;
        add_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    tos_next        = tos;
    opa_next        = opa;
    opb_next        = opb;
    acc_next        = acc;
    step_next       = step;
    neg_next        = neg;
    kind_q_next     = kind_q;
    res_status_next = res_status;
    res_value_next  = res_value;
    sop_next        = sop;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    mem_we          = 1'b0;
    mem_waddr       = count[IW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          kind_q_next = s_tuser;
          state_next  = S_DONE;
          sop_next    = SOP_NONE;
          case (s_tuser)
            TK_DIGIT: begin
              if (count >= CW'(STACK_DEPTH)) begin
                res_status_next = ST_OVERFLOW;
                res_value_next  = tos;
              end else begin
                res_status_next = ST_OK;
                res_value_next  = W'(s_tdata[3:0]);
                sop_next        = SOP_PUSH;
              end
            end
            TK_ADD, TK_SUB, TK_MUL, TK_DIV: begin
              if (count < CW'(2)) begin
                res_status_next = ST_FEW;
                res_value_next  = (count == '0) ? '0 : tos;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: begin
              sop_next = SOP_CLEAR;
              if (count == CW'(1)) begin
                res_status_next = ST_READY;
                res_value_next  = tos;
              end else begin
                res_status_next = ST_ILLEGAL;
                res_value_next  = '0;
              end
            end
          endcase
        end
      end

      S_FETCH: begin
        res_status_next = ST_OK;
        sop_next        = SOP_POP;
        step_next       = '0;
        case (kind_q)
          TK_MUL: begin
            opa_next   = rd_data;
            opb_next   = tos;
            acc_next   = '0;
            state_next = S_MUL;
          end
          TK_DIV: begin
            if (tos == '0) begin
              res_status_next = ST_DIVZERO;
              res_value_next  = '0;
              state_next      = S_DONE;
            end else begin
              neg_next   = rd_data[W-1] ^ tos[W-1];
              acc_next   = s_mag;
              opa_next   = '0;
              opb_next   = t_mag;
              state_next = S_DIV;
            end
          end
          default: begin
            res_value_next = add_sum[W-1:0];
            state_next     = S_DONE;
          end
        endcase
      end

      S_MUL: begin
        if (opb[0]) begin
          acc_next = add_sum[W-1:0];
        end
        opa_next  = {opa[W-2:0], 1'b0};
        opb_next  = {1'b0, opb[W-1:1]};
        step_next = step + SW'(1);
        if (last_step) begin
          res_value_next = opb[0] ? add_sum[W-1:0] : acc;
          state_next     = S_DONE;
        end
      end

      S_DIV: begin
        // restoring step: carry out means no borrow
        opa_next  = add_sum[W] ? add_sum[W-1:0] : rem_sh;
        acc_next  = {acc[W-2:0], add_sum[W]};
        step_next = step + SW'(1);
        if (last_step) begin
          res_value_next = {acc[W-2:0], add_sum[W]};
          state_next     = neg ? S_NEG : S_DONE;
        end
      end

      S_NEG: begin
        res_value_next = add_sum[W-1:0];
        state_next     = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = 32'($signed(res_value));
          m_tuser_next  = res_status;
          state_next    = S_IDLE;
          case (sop)
            SOP_PUSH: begin
              mem_we     = 1'b1;
              mem_waddr  = count[IW-1:0];
              count_next = count + CW'(1);
              tos_next   = res_value;
            end
            SOP_POP: begin
              mem_we     = 1'b1;
              mem_waddr  = rd_addr;
              count_next = count - CW'(1);
              tos_next   = res_value;
            end
            SOP_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    tos        <= tos_next;
    opa        <= opa_next;
    opb        <= opb_next;
    acc        <= acc_next;
    step       <= step_next;
    neg        <= neg_next;
    kind_q     <= kind_q_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    sop        <= sop_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= res_value;
    end
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
